// ===== hdl/vnh_pkg.sv =====
// ----------------------------------------------------------------------------
// vnh_pkg
// Shared types, widths and the lattice hash table for the value noise
// heightmap pipeline.
// ----------------------------------------------------------------------------
package vnh_pkg;

  localparam int COORD_W  = 10;
  localparam int SEED_W   = 8;
  localparam int LAT_W    = 8;   // lattice index, wraps modulo 256
  localparam int FRAC_W   = 4;   // fraction, always scaled to a step of 16
  localparam int WGT_W    = 12;  // smoothstep weight in units of 16^-3
  localparam int LO_W     = 20;  // x blend in units of 16^-3
  localparam int OCT_W    = 32;  // y blend in units of 16^-6
  localparam int HEIGHT_W = 16;
  localparam int SUM_W    = 33;
  localparam int NSTG     = 6;   // register stages from input to height

  localparam logic [7:0] HASH_TABLE [256] = '{
    8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
    8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
    8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
    8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
    8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
    8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
    8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
    8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
    8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
    8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
    8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
    8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
    8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
    8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
    8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
    8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
    8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
    8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
    8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
    8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
    8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
    8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
    8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
    8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
    8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
    8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
    8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
    8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
    8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
    8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
    8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
    8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
  };

  // Stage load strobes for one octave unit
  typedef struct packed {
    logic ld_row;
    logic ld_row_hash;
    logic ld_corner;
    logic ld_xblend;
    logic ld_yblend;
  } oct_ctl_t;

  // f*f*(48-2f) for a fraction f of 16
  function automatic logic [WGT_W-1:0] smooth_weight(input logic [FRAC_W-1:0] f);
    logic [7:0]  f2;
    logic [5:0]  span;
    logic [13:0] prod;
    f2   = {4'd0, f} * {4'd0, f};
    span = 6'd48 - {1'b0, f, 1'b0};
    prod = {6'd0, f2} * {8'd0, span};
    return prod[WGT_W-1:0];
  endfunction

endpackage

// ===== hdl/vnh_octave.sv =====
// ----------------------------------------------------------------------------
// vnh_octave
// One octave of 2D value noise: row hash, corner hash, x blend, y blend.
// Fractions arrive scaled to a step of 16, so the result is always in
// units of 2^-24.
// ----------------------------------------------------------------------------
module vnh_octave import vnh_pkg::*; (
  input  logic                  clk,
  input  oct_ctl_t              ctl,
  input  logic [SEED_W-1:0]     seed,
  input  logic [LAT_W-1:0]      xi,
  input  logic [LAT_W-1:0]      yi,
  input  logic [FRAC_W-1:0]     fx,
  input  logic [FRAC_W-1:0]     fy,
  output logic [OCT_W-1:0]      oct
);

  // stage A
  logic [LAT_W-1:0] row0, row1, xi_a;
  logic [WGT_W-1:0] wx_a, wy_a;
  // stage B
  logic [7:0]       hr0, hr1;
  logic [LAT_W-1:0] xi_b;
  logic [WGT_W-1:0] wx_b, wy_b;
  // stage C
  logic [7:0]       cs, ct, cu, cv;
  logic [WGT_W-1:0] wx_c, wy_c;
  // stage D
  logic [LO_W-1:0]  lo, hi;
  logic [WGT_W-1:0] wy_d;

  logic [LAT_W-1:0]   col0, col0p, col1, col1p;
  logic signed [8:0]  d_ts, d_vu;
  logic signed [21:0] p_ts, p_vu, lo_full, hi_full;
  logic [LO_W-1:0]    lo_next, hi_next;
  logic signed [20:0] d_hl;
  logic signed [33:0] p_hl, oct_full;
  logic [OCT_W-1:0]   oct_next;

  always_ff @(posedge clk) begin
    if (ctl.ld_row) begin
      row0 <= yi + seed;
      row1 <= yi + seed + 8'd1;
      xi_a <= xi;
      wx_a <= smooth_weight(fx);
      wy_a <= smooth_weight(fy);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_row_hash) begin
      hr0  <= HASH_TABLE[row0];
      hr1  <= HASH_TABLE[row1];
      xi_b <= xi_a;
      wx_b <= wx_a;
      wy_b <= wy_a;
    end
  end

  always_comb begin
    col0  = hr0 + xi_b;
    col0p = hr0 + xi_b + 8'd1;
    col1  = hr1 + xi_b;
    col1p = hr1 + xi_b + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_corner) begin
      cs   <= HASH_TABLE[col0];
      ct   <= HASH_TABLE[col0p];
      cu   <= HASH_TABLE[col1];
      cv   <= HASH_TABLE[col1p];
      wx_c <= wx_b;
      wy_c <= wy_b;
    end
  end

  // x blend: s*4096 + (t-s)*wx, always within [0, 255*4096]
  always_comb begin
    d_ts    = $signed({1'b0, ct}) - $signed({1'b0, cs});
    d_vu    = $signed({1'b0, cv}) - $signed({1'b0, cu});
    p_ts    = d_ts * $signed({1'b0, wx_c});
    p_vu    = d_vu * $signed({1'b0, wx_c});
    lo_full = $signed({2'b00, cs, 12'd0}) + p_ts;
    hi_full = $signed({2'b00, cu, 12'd0}) + p_vu;
    lo_next = lo_full[LO_W-1:0];
    hi_next = hi_full[LO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_xblend) begin
      lo   <= lo_next;
      hi   <= hi_next;
      wy_d <= wy_c;
    end
  end

  // y blend
  always_comb begin
    d_hl     = $signed({1'b0, hi}) - $signed({1'b0, lo});
    p_hl     = d_hl * $signed({1'b0, wy_d});
    oct_full = $signed({2'b00, lo, 12'd0}) + p_hl;
    oct_next = oct_full[OCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_yblend) begin
      oct <= oct_next;
    end
  end

endmodule

// ===== hdl/value_noise_heightmap.sv =====
// ----------------------------------------------------------------------------
// value_noise_heightmap
// Three-octave value noise terrain height per tile coordinate.
// ----------------------------------------------------------------------------
// Takes one coordinate word per clock while in_ready is high and returns one
// height word for each, in order. The block is a six-stage pipeline (row
// offset and weights, row hash, corner hash, x blend, y blend, octave sum) with
// a valid bit per stage; throughput is one word per cycle while the output is
// not held off. A stall at the output fills empty stages first and only then
// drops in_ready. The seed is written through cfg_we and cfg_wdata and should
// only change while no word is in flight.
module value_noise_heightmap import vnh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [SEED_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   tile_x,
  input  logic [COORD_W-1:0]   tile_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HEIGHT_W-1:0]  height
);

  logic [SEED_W-1:0] seed;
  logic [NSTG-1:0]   vld;
  logic [NSTG-1:0]   rdy;
  oct_ctl_t          ctl;

  logic [LAT_W-1:0]  xi4, yi4, xi3, yi3, xi2, yi2;
  logic [FRAC_W-1:0] fx4, fy4, fx3, fy3, fx2, fy2;
  logic [OCT_W-1:0]  oct4, oct3, oct2;
  logic [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  // a stage may take a word when it is empty or its word moves on
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    ctl.ld_row      = rdy[0] && in_valid;
    ctl.ld_row_hash = rdy[1] && vld[0];
    ctl.ld_corner   = rdy[2] && vld[1];
    ctl.ld_xblend   = rdy[3] && vld[2];
    ctl.ld_yblend   = rdy[4] && vld[3];
  end

  // lattice steps 16, 8 and 4; fractions rescaled to a step of 16
  always_comb begin
    xi4 = {2'b00, tile_x[9:4]};
    yi4 = {2'b00, tile_y[9:4]};
    fx4 = tile_x[3:0];
    fy4 = tile_y[3:0];
    xi3 = {1'b0, tile_x[9:3]};
    yi3 = {1'b0, tile_y[9:3]};
    fx3 = {tile_x[2:0], 1'b0};
    fy3 = {tile_y[2:0], 1'b0};
    xi2 = tile_x[9:2];
    yi2 = tile_y[9:2];
    fx2 = {tile_x[1:0], 2'b00};
    fy2 = {tile_y[1:0], 2'b00};
  end

  vnh_octave u_oct4 (
    .clk (clk), .ctl (ctl), .seed (seed),
    .xi (xi4), .yi (yi4), .fx (fx4), .fy (fy4), .oct (oct4)
  );

  vnh_octave u_oct3 (
    .clk (clk), .ctl (ctl), .seed (seed),
    .xi (xi3), .yi (yi3), .fx (fx3), .fy (fy3), .oct (oct3)
  );

  vnh_octave u_oct2 (
    .clk (clk), .ctl (ctl), .seed (seed),
    .xi (xi2), .yi (yi2), .fx (fx2), .fy (fy2), .oct (oct2)
  );

  // weights 1/2, 1/4, 1/8 after the 1/256 scale, all in units of 2^-33;
  // the rescaled finer octaves carry spare low zeros, so the shifts are exact
  always_comb begin
    sum = {1'b0, oct4} + {2'b00, oct3[OCT_W-1:1]} + {3'b000, oct2[OCT_W-1:2]};
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1] && vld[NSTG-2]) begin
      height <= sum[SUM_W-1:SUM_W-HEIGHT_W];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTG-1];

endmodule

// ===== hdl/vnh_checker.sv =====
// ----------------------------------------------------------------------------
// vnh_checker
// Port-level checks for the heightmap pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module vnh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] height
);

  // nothing comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // an empty output stage means the whole pipe can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held off with empty output stage");

  // an accepted word reaches the output stage while the output keeps draining
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("word did not reach the output in time");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(height)))
    else $error("stalled output word changed");

endmodule

bind value_noise_heightmap vnh_checker u_vnh_checker (.*);
